@@ rtl/pstx_pkg.sv @@
package pstx_pkg;

    // Bytes held by the two 64-bit prefix registers
    localparam int unsigned PREFIX_REG_BYTES = 16;
    localparam int unsigned CFG_DATA_W       = 64;
    localparam int unsigned CFG_INDEX_W      = 2;
    localparam int unsigned LEN_W            = 5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PREFIX_LEN  = 2'd2;

    localparam logic [LEN_W-1:0] PREFIX_LEN_RESET = 5'd16;

    // Prefix settings as seen by the scanner; len is already clamped
    typedef struct packed {
        logic [PREFIX_REG_BYTES-1:0][7:0] prefix;
        logic [LEN_W-1:0]                 len;
    } cfg_t;

    // One result item, valid says whether the item produced one
    typedef struct packed {
        logic       valid;
        logic [7:0] name_byte;
        logic       byte_valid;
        logic       name_end;
    } result_t;

endpackage

@@ rtl/prefix_tagged_string_extractor_top.sv @@
// Accepted items pass the input reg, then the result reg that drives m_tvalid.
// One item per cycle unless m_tready stalls; compare is a single pass of byte comparators.
// Items that produce no result are consumed without an output item.
// Reset: aresetn synchronous active low; clears window, mode, config and both valid regs.
// Config registers come up as prefix all zero, length 16.
module prefix_tagged_string_extractor_top #(
    parameter int unsigned MAX_PREFIX = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [pstx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pstx_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] stream_byte
    input  logic                              s_tlast,   // stream_last
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] name_byte
    output logic                              m_tuser,   // [0] byte_valid
    output logic                              m_tlast    // name_end
);

    pstx_pkg::cfg_t    cfg;
    pstx_pkg::result_t res;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bvalid_reg;
    logic       out_end_reg;
    logic       advance;

    pstx_cfg #(.MAX_PREFIX(MAX_PREFIX)) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pstx_scan #(.MAX_PREFIX(MAX_PREFIX)) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (advance),
        .item_byte  (in_byte_reg),
        .item_last  (in_last_reg),
        .res        (res)
    );

    // Held item moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_byte_reg   <= res.name_byte;
            out_bvalid_reg <= res.byte_valid;
            out_end_reg    <= res.name_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_bvalid_reg;
    assign m_tlast  = out_end_reg;

endmodule

@@ rtl/pstx_cfg.sv @@
module pstx_cfg #(
    parameter int unsigned MAX_PREFIX = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pstx_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pstx_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output pstx_pkg::cfg_t                      cfg
);

    logic [63:0]               prefix_low_reg;
    logic [63:0]               prefix_high_reg;
    logic [pstx_pkg::LEN_W-1:0] len_reg;

    // Register writes; an unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_low_reg  <= '0;
            prefix_high_reg <= '0;
            len_reg         <= pstx_pkg::PREFIX_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pstx_pkg::REG_PREFIX_LOW:  prefix_low_reg  <= cfg_wdata;
                pstx_pkg::REG_PREFIX_HIGH: prefix_high_reg <= cfg_wdata;
                pstx_pkg::REG_PREFIX_LEN:  len_reg <= cfg_wdata[pstx_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective length: zero counts as one, saturate at MAX_PREFIX
    always_comb begin
        cfg.prefix = {prefix_high_reg, prefix_low_reg};
        if (len_reg == '0) begin
            cfg.len = pstx_pkg::LEN_W'(1);
        end else if (len_reg > pstx_pkg::LEN_W'(MAX_PREFIX)) begin
            cfg.len = pstx_pkg::LEN_W'(MAX_PREFIX);
        end else begin
            cfg.len = len_reg;
        end
    end

endmodule

@@ rtl/pstx_scan.sv @@
module pstx_scan #(
    parameter int unsigned MAX_PREFIX = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pstx_pkg::cfg_t      cfg,
    input  logic                item_valid,
    input  logic [7:0]          item_byte,
    input  logic                item_last,
    output pstx_pkg::result_t   res
);

    localparam int unsigned FILL_W = $clog2(MAX_PREFIX + 1);
    localparam int unsigned IDX_W  = $clog2(pstx_pkg::PREFIX_REG_BYTES);

    logic [MAX_PREFIX-1:0][7:0] win_reg, win_next, win_sh;
    logic [FILL_W-1:0]          fill_reg, fill_next, fill_sh;
    logic                       extracting_reg, extracting_next;
    logic [MAX_PREFIX-1:0]      byte_ok;
    logic                       match;

    // Window with the new byte shifted in at entry 0
    always_comb begin
        win_sh[0] = item_byte;
        for (int j = 1; j < MAX_PREFIX; j++) begin
            win_sh[j] = win_reg[j-1];
        end
        fill_sh = (fill_reg == FILL_W'(MAX_PREFIX)) ? fill_reg : fill_reg + FILL_W'(1);
    end

    // Entry j lines up with prefix byte len-1-j; entries past len don't care
    always_comb begin
        logic [pstx_pkg::LEN_W-1:0] pidx;
        for (int j = 0; j < MAX_PREFIX; j++) begin
            pidx = cfg.len - pstx_pkg::LEN_W'(j + 1);
            if (pstx_pkg::LEN_W'(j) < cfg.len) begin
                byte_ok[j] = (win_sh[j] == cfg.prefix[pidx[IDX_W-1:0]]);
            end else begin
                byte_ok[j] = 1'b1;
            end
        end
        match = (pstx_pkg::LEN_W'(fill_sh) >= cfg.len) && (&byte_ok);
    end

    // Mode control and result for the current item
    always_comb begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        extracting_next = extracting_reg;
        res             = '0;

        if (extracting_reg) begin
            if (item_byte != 8'd0) begin
                res.valid      = 1'b1;
                res.name_byte  = item_byte;
                res.byte_valid = 1'b1;
                res.name_end   = item_last;
            end else begin
                // NUL closes the name and is scanned as a normal byte
                res.valid  = 1'b1;
                res.name_end = 1'b1;
                if (match) begin
                    win_next        = '0;
                    fill_next       = '0;
                    extracting_next = 1'b1;
                end else begin
                    win_next        = win_sh;
                    fill_next       = fill_sh;
                    extracting_next = 1'b0;
                end
            end
        end else if (match) begin
            win_next        = '0;
            fill_next       = '0;
            extracting_next = 1'b1;
            // Match on the final byte: close the empty name
            res.valid    = item_last;
            res.name_end = item_last;
        end else begin
            win_next  = win_sh;
            fill_next = fill_sh;
        end

        // End of stream returns the scanner to its reset state
        if (item_last) begin
            win_next        = '0;
            fill_next       = '0;
            extracting_next = 1'b0;
        end

        if (!item_valid) begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg        <= '0;
            fill_reg       <= '0;
            extracting_reg <= 1'b0;
        end else if (item_valid) begin
            win_reg        <= win_next;
            fill_reg       <= fill_next;
            extracting_reg <= extracting_next;
        end
    end

    // Window stays empty for the whole of a name
    a_empty_while_extracting: assert property (@(posedge aclk) disable iff (!aresetn)
        extracting_reg |-> (fill_reg == '0))
        else $error("window not empty while extracting");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_PREFIX))
        else $error("fill count past window depth");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item_last) |=> (!extracting_reg && fill_reg == '0))
        else $error("state not cleared after last byte");

    a_bare_mark_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res.byte_valid) |-> (res.name_end && res.name_byte == 8'd0))
        else $error("bare mark without name end");

endmodule
